FILE: hdl/tog_pkg.sv
package tog_pkg;

  // Input operation codes
  localparam logic OP_CURSOR = 1'b0;
  localparam logic OP_TEXT   = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COLOR_Y      = 3'd2;
  localparam logic [2:0] REG_COLOR_CB     = 3'd3;
  localparam logic [2:0] REG_COLOR_CR     = 3'd4;

  // Special glyph codes
  localparam logic [7:0] CODE_TAB     = 8'hFD;
  localparam logic [7:0] CODE_NEWLINE = 8'hFE;
  localparam logic [7:0] CODE_BLANK   = 8'hFF;
  localparam logic [7:0] HIGH_BANK    = 8'd100;

  // Geometry
  localparam logic [9:0]  WIDE_MIN   = 10'd400;
  localparam logic [9:0]  TALL_MIN   = 10'd300;
  localparam logic [15:0] CELL_W     = 16'd6;
  localparam logic [15:0] CELL_H     = 16'd7;
  localparam logic [15:0] TAB_STOP   = 16'd48;
  localparam logic [2:0]  LAST_ROW   = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB,
    ST_TAB_DONE,
    ST_SETUP,
    ST_ADDR,
    ST_FIRST,
    ST_EMIT
  } state_t;

  // Font ROM read request
  typedef struct packed {
    logic       en;
    logic       hi;
    logic [7:0] idx;
  } rom_req_t;

  // One pixel pair handed to the output stage
  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
    logic       rpt;
    logic       last;
  } emit_t;

  // Text byte to glyph code
  localparam logic [7:0] CHAR_CODE [128] = '{
    8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A,
    8'h7A, 8'hFD, 8'hFE, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'h29, 8'h64, 8'h65, 8'h66, 8'h2B, 8'h67, 8'h68,
    8'h25, 8'h26, 8'h69, 8'h2A, 8'h6A, 8'h27, 8'h2C, 8'h6B,
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h24, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h28,
    8'h70, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
    8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20,
    8'h21, 8'h22, 8'h23, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75,
    8'hFF, 8'h7D, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83,
    8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
    8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93,
    8'h94, 8'h95, 8'h96, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A
  };

endpackage

FILE: hdl/tog_font_rom.sv
module tog_font_rom
  import tog_pkg::*;
(
  input  logic        clk,
  input  rom_req_t    req,
  output logic [31:0] rd_data
);

  // Codes below 100: five glyphs share each group of seven row words
  localparam logic [31:0] FONT_LO [64] = '{
    32'h70871C30, 32'h8988A250, 32'h88808290, 32'h88830C90,
    32'h888402F8, 32'h88882210, 32'h71CF9C10, 32'hF9CF9C70,
    32'h8208A288, 32'hF200A288, 32'h0BC11C78, 32'h0A222208,
    32'h8A222208, 32'h71C21C70, 32'h23C738F8, 32'h5228A480,
    32'h8A282280, 32'h8BC822F0, 32'hFA282280, 32'h8A28A480,
    32'h8BC738F8, 32'hF9C89C08, 32'h82288808, 32'h82088808,
    32'hF2EF8808, 32'h82288888, 32'h82288888, 32'h81C89C70,
    32'h8A08A270, 32'h920DA288, 32'hA20AB288, 32'hC20AAA88,
    32'hA208A688, 32'h9208A288, 32'h8BE8A270, 32'hF1CF1CF8,
    32'h8A28A220, 32'h8A28A020, 32'hF22F1C20, 32'h82AA0220,
    32'h82492220, 32'h81A89C20, 32'h8A28A288, 32'h8A28A288,
    32'h8A289488, 32'h8A2A8850, 32'h894A9420, 32'h894AA220,
    32'h70852220, 32'hF8011000, 32'h08020800, 32'h10840400,
    32'h20040470, 32'h40840400, 32'h80020800, 32'hF8011000,
    32'h70800000, 32'h88822200, 32'h08820400, 32'h108F8800,
    32'h20821000, 32'h00022200, 32'h20800020, 32'h00000000
  };

  // Codes 100 and up
  localparam logic [31:0] FONT_HI [77] = '{
    32'h51421820, 32'h53E7A420, 32'h014A2C40, 32'h01471000,
    32'h0142AA00, 32'h03EAA400, 32'h01471A78, 32'h00000000,
    32'h50008010, 32'h20010820, 32'hF8020040, 32'h20420820,
    32'h50441010, 32'h00880000, 32'h00070E00, 32'h01088840,
    32'h78898820, 32'h004A8810, 32'h788A8810, 32'h01098808,
    32'h00040E04, 32'h70800620, 32'h11400820, 32'h12200820,
    32'h10001020, 32'h10000820, 32'h100F8820, 32'h70000620,
    32'h60070000, 32'h110F82A0, 32'h12AA8AE0, 32'h084F92A0,
    32'h100FBE1C, 32'h10089008, 32'h60070808, 32'h00000000,
    32'h02000200, 32'h7A078270, 32'h8BC81E88, 32'h8A2822F8,
    32'h9A282280, 32'h6BC79E78, 32'h30000000, 32'h48080810,
    32'h41E80000, 32'h422F1830, 32'hFBE88810, 32'h40288890,
    32'h43C89C60, 32'h81000000, 32'h81000000, 32'h990F3C70,
    32'hA10AA288, 32'hE10AA288, 32'hA10AA288, 32'h98CAA270,
    32'h00000000, 32'h00000020, 32'hF1EF1E20, 32'h8A28A0F8,
    32'h8A281C20, 32'hF1E80220, 32'h80283C38, 32'h00000000,
    32'h00000000, 32'h8A28B688, 32'h8A2A8888, 32'h8A2A8878,
    32'h894A8808, 32'h788536F0, 32'h00000000, 32'h00000000,
    32'hF8000000, 32'h10000000, 32'h20000000, 32'h40000000,
    32'hF8000000
  };

  logic [31:0] rom_q_r;

  // Registered read; rows past the end of a bank read as blank
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.hi) begin
        rom_q_r <= (req.idx < 8'd77) ? FONT_HI[req.idx[6:0]] : 32'h0;
      end else begin
        rom_q_r <= (req.idx < 8'd64) ? FONT_LO[req.idx[5:0]] : 32'h0;
      end
    end
  end

  assign rd_data = rom_q_r;

endmodule

FILE: hdl/tog_seq.sv
module tog_seq
  import tog_pkg::*;
#(
  parameter int ADDR_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [15:0]          in_start_x,
  input  logic [15:0]          in_start_y,
  input  logic [7:0]           in_char_code,
  input  logic [9:0]           frame_width,
  input  logic [9:0]           frame_height,
  output rom_req_t             rom_req,
  input  logic [31:0]          rom_data,
  input  logic                 out_free,
  output emit_t                emit,
  output logic [ADDR_BITS-1:0] pair_addr
);

  localparam logic [17:0] TAB_BIAS    = 18'd47;
  localparam logic [11:0] THIRD_RECIP = 12'd2731;

  state_t state_r, state_nxt;

  logic [15:0] cursor_x_r, cursor_y_r, line_start_r;
  logic [7:0]  code_r;
  logic        g_hi_r;
  logic [4:0]  q_r;
  logic [2:0]  col_sel_r;
  logic [ADDR_BITS-1:0] prod_r, row_addr_r, pix_addr_r;
  logic [2:0]  rd_row_r, row_r, k_r;
  logic [15:0] bits_r;
  logic [16:0] tab_rem_r;
  logic        tab_neg_r;

  // Frame geometry
  logic        wide, tall;
  logic [10:0] stride_sum, stride;
  logic [11:0] rowstep;

  assign wide       = frame_width >= WIDE_MIN;
  assign tall       = frame_height >= TALL_MIN;
  assign stride_sum = {1'b0, frame_width} + 11'd15;
  assign stride     = {stride_sum[10:4], 4'b0000};
  assign rowstep    = tall ? {stride, 1'b0} : {1'b0, stride};

  // Input decode
  logic       accept;
  logic [7:0] in_code;
  logic       is_glyph;

  assign accept   = in_valid && in_ready;
  assign in_code  = CHAR_CODE[in_char_code[6:0]];
  assign is_glyph = (in_code != CODE_TAB) && (in_code != CODE_NEWLINE) &&
                    (in_code != CODE_BLANK);

  // Tab remainder set-up: signed distance plus bias, split into sign and magnitude
  logic [17:0] tab_d, tab_d_neg;
  logic [16:0] tab_mag;
  logic [15:0] tab_new;

  assign tab_d     = {2'b00, cursor_x_r} - {2'b00, line_start_r} + TAB_BIAS;
  assign tab_d_neg = 18'd0 - tab_d;
  assign tab_mag   = tab_d[17] ? tab_d_neg[16:0] : tab_d[16:0];
  assign tab_new   = tab_neg_r ? (cursor_x_r + TAB_STOP + tab_rem_r[15:0])
                               : (cursor_x_r + TAB_STOP - tab_rem_r[15:0]);

  // Magnitude mod 48: low nibble kept, upper part mod 3 by reciprocal multiply
  logic [12:0] tab_hi, tab_q3, tab_m3;
  logic [24:0] tab_q_prod;
  logic [11:0] tab_q;
  logic [5:0]  tab_rem48;

  assign tab_hi     = tab_rem_r[16:4];
  assign tab_q_prod = {12'd0, tab_hi} * {13'd0, THIRD_RECIP};
  assign tab_q      = tab_q_prod[24:13];
  assign tab_q3     = {tab_q, 1'b0} + {1'b0, tab_q};
  assign tab_m3     = tab_hi - tab_q3;
  assign tab_rem48  = {tab_m3[1:0], tab_rem_r[3:0]};

  // Glyph number within its bank, then group (by reciprocal) and column slot
  logic [7:0]  g8;
  logic [6:0]  g7;
  logic [14:0] q_prod;
  logic [4:0]  q_calc;
  logic [6:0]  q_times5;
  logic [6:0]  col_calc;

  assign g8       = (code_r >= HIGH_BANK) ? (code_r - HIGH_BANK) : code_r;
  assign g7       = g8[6:0];
  assign q_prod   = {8'b0, g7} * 15'd205;
  assign q_calc   = q_prod[14:10];
  assign q_times5 = {q_calc, 2'b00} + {2'b00, q_calc};
  assign col_calc = g7 - q_times5;

  // Base address of the cell
  logic [26:0] prod27;
  logic [27:0] prod28;
  logic [16:0] cx_scaled;
  logic [ADDR_BITS-1:0] base_addr, next_row_addr;
  logic [7:0]  q7;

  assign prod27        = 27'(stride) * 27'(cursor_y_r);
  assign prod28        = tall ? {prod27, 1'b0} : {1'b0, prod27};
  assign cx_scaled     = wide ? {cursor_x_r, 1'b0} : {1'b0, cursor_x_r};
  assign base_addr     = prod_r + ADDR_BITS'(cx_scaled);
  assign next_row_addr = row_addr_r + ADDR_BITS'(rowstep);
  assign q7            = {q_r, 3'b000} - {3'b000, q_r};

  // ROM word to the 16-bit window of glyph bits for one row
  logic [5:0]  top6;
  logic [11:0] dup12;
  logic [15:0] row_bits;

  always_comb begin
    unique case (col_sel_r)
      3'd0:    top6 = rom_data[31:26];
      3'd1:    top6 = rom_data[25:20];
      3'd2:    top6 = rom_data[19:14];
      3'd3:    top6 = rom_data[13:8];
      3'd4:    top6 = rom_data[7:2];
      default: top6 = 6'b0;
    endcase
    for (int i = 0; i < 6; i++) begin
      dup12[2*i +: 2] = {2{top6[i]}};
    end
    row_bits = wide ? {1'b0, dup12, 3'b000} : {1'b0, top6, 9'b0};
  end

  logic k_end, row_last;

  assign k_end    = (k_r == (wide ? 3'd5 : 3'd2));
  assign row_last = (row_r == LAST_ROW);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_TEXT) begin
          if (in_code == CODE_TAB) begin
            state_nxt = ST_TAB;
          end else if (is_glyph) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_TAB:      state_nxt = ST_TAB_DONE;
      ST_TAB_DONE: state_nxt = ST_IDLE;
      ST_SETUP:    state_nxt = ST_ADDR;
      ST_ADDR:     state_nxt = ST_FIRST;
      ST_FIRST:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free && k_end && row_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    rom_req.en   = (state_r == ST_ADDR) || (state_r == ST_FIRST) ||
                   ((state_r == ST_EMIT) && out_free && k_end && !row_last);
    rom_req.hi   = g_hi_r;
    rom_req.idx  = q7 + {5'b0, rd_row_r};
    emit.valid   = (state_r == ST_EMIT) && out_free;
    emit.nib     = bits_r[15:12];
    emit.rpt     = tall;
    emit.last    = row_last && k_end;
    pair_addr    = pix_addr_r;
  end

  // Control state and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      line_start_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && accept) begin
        if (in_op == OP_CURSOR) begin
          cursor_x_r   <= in_start_x;
          line_start_r <= in_start_x;
          cursor_y_r   <= in_start_y;
        end else if (in_code == CODE_NEWLINE) begin
          cursor_x_r <= line_start_r;
          cursor_y_r <= cursor_y_r + CELL_H;
        end else if (in_code == CODE_BLANK) begin
          cursor_x_r <= cursor_x_r + CELL_W;
        end
      end
      if (state_r == ST_ADDR) begin
        cursor_x_r <= cursor_x_r + CELL_W;
      end
      if (state_r == ST_TAB_DONE) begin
        cursor_x_r <= tab_new;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        code_r    <= in_code;
        tab_rem_r <= tab_mag;
        tab_neg_r <= tab_d[17];
      end
      ST_TAB: begin
        tab_rem_r <= {11'd0, tab_rem48};
      end
      ST_SETUP: begin
        g_hi_r    <= (code_r >= HIGH_BANK);
        q_r       <= q_calc;
        col_sel_r <= col_calc[2:0];
        prod_r    <= ADDR_BITS'(prod28);
        rd_row_r  <= 3'd0;
      end
      ST_ADDR: begin
        row_addr_r <= base_addr;
        pix_addr_r <= base_addr;
        rd_row_r   <= rd_row_r + 3'd1;
        row_r      <= 3'd0;
        k_r        <= 3'd0;
      end
      ST_FIRST: begin
        bits_r   <= row_bits;
        rd_row_r <= rd_row_r + 3'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (k_end) begin
            k_r <= 3'd0;
            if (!row_last) begin
              // next row: its word was prefetched at the previous row load
              row_r      <= row_r + 3'd1;
              row_addr_r <= next_row_addr;
              pix_addr_r <= next_row_addr;
              bits_r     <= row_bits;
              rd_row_r   <= rd_row_r + 3'd1;
            end
          end else begin
            k_r        <= k_r + 3'd1;
            pix_addr_r <= pix_addr_r + ADDR_BITS'(2);
            bits_r     <= {bits_r[13:0], 2'b00};
          end
        end
      end
      default: begin
        k_r <= 3'd0;
      end
    endcase
  end

endmodule

FILE: hdl/tog_out.sv
module tog_out
  import tog_pkg::*;
#(
  parameter int ADDR_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  emit_t                emit,
  input  logic [ADDR_BITS-1:0] pair_addr,
  input  logic [7:0]           color_y,
  input  logic [7:0]           color_cb,
  input  logic [7:0]           color_cr,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [19:0]          out_pixel_index,
  output logic [15:0]          out_left_value,
  output logic [15:0]          out_right_value,
  output logic                 out_repeat_next_row,
  output logic                 out_last
);

  localparam int EXT_W = (ADDR_BITS > 20) ? ADDR_BITS : 20;
  localparam logic [7:0] QTR_OFF  = 8'd32;
  localparam logic [7:0] HALF_OFF = 8'd64;

  logic        out_valid_r;
  logic [19:0] index_r;
  logic [15:0] left_r, right_r;
  logic        rpt_r, last_r;

  // Chroma blend from the bit under the pixel and its neighbors
  logic        b31, b30, b29, b28;
  logic [7:0]  cb2, cb4, cr2, cr4, cb_sum, cr_sum;
  logic [15:0] left_val, right_val;
  logic [EXT_W-1:0] addr_ext;

  assign b31 = emit.nib[3];
  assign b30 = emit.nib[2];
  assign b29 = emit.nib[1];
  assign b28 = emit.nib[0];
  assign cb2 = {1'b0, color_cb[7:1]};
  assign cb4 = {2'b00, color_cb[7:2]};
  assign cr2 = {1'b0, color_cr[7:1]};
  assign cr4 = {2'b00, color_cr[7:2]};

  assign cb_sum = (b31 ? cb4 : QTR_OFF) + (b30 ? cb2 : HALF_OFF) + (b29 ? cb4 : QTR_OFF);
  assign cr_sum = (b30 ? cr4 : QTR_OFF) + (b29 ? cr2 : HALF_OFF) + (b28 ? cr4 : QTR_OFF);

  assign left_val  = {(b30 ? color_y : 8'h00), cb_sum};
  assign right_val = {(b29 ? color_y : 8'h00), cr_sum};
  assign addr_ext  = EXT_W'(pair_addr);

  // Output register: a new pair loads when the slot is empty or being drained
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      index_r <= addr_ext[19:0];
      left_r  <= left_val;
      right_r <= right_val;
      rpt_r   <= emit.rpt;
      last_r  <= emit.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_index     = index_r;
  assign out_left_value      = left_r;
  assign out_right_value     = right_r;
  assign out_repeat_next_row = rpt_r;
  assign out_last            = last_r;

endmodule

FILE: hdl/text_overlay_glyph_renderer_core.sv
// Glyph: the sequencer passes setup, address and first-row states, then sends one
// pair per cycle while the output stage is free (21 pairs, 42 in wide frames); input
// is ready again when the last pair enters the output register. The font ROM read
// port and the pair sequencer set that pace. Tab: remainder by reciprocal multiply.
// Synchronous active-low reset clears cursor, sequencer, output valid and sets
// the color and frame registers to their defaults.
module text_overlay_glyph_renderer_core
  import tog_pkg::*;
#(
  parameter int ADDR_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_pixel_index,
  output logic [15:0] out_left_value,
  output logic [15:0] out_right_value,
  output logic        out_repeat_next_row,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [9:0] frame_width_r, frame_height_r;
  logic [7:0] color_y_r, color_cb_r, color_cr_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 10'd0;
      frame_height_r <= 10'd0;
      color_y_r      <= 8'd235;
      color_cb_r     <= 8'd128;
      color_cr_r     <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_COLOR_Y:      color_y_r      <= cfg_data[7:0];
        REG_COLOR_CB:     color_cb_r     <= cfg_data[7:0];
        REG_COLOR_CR:     color_cr_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rom_req_t             rom_req;
  logic [31:0]          rom_data;
  emit_t                emit;
  logic [ADDR_BITS-1:0] pair_addr;
  logic                 out_free;

  tog_font_rom u_rom (
    .clk     (clk),
    .req     (rom_req),
    .rd_data (rom_data)
  );

  tog_seq #(.ADDR_BITS(ADDR_BITS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_char_code (in_char_code),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .rom_req      (rom_req),
    .rom_data     (rom_data),
    .out_free     (out_free),
    .emit         (emit),
    .pair_addr    (pair_addr)
  );

  tog_out #(.ADDR_BITS(ADDR_BITS)) u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .emit                (emit),
    .pair_addr           (pair_addr),
    .color_y             (color_y_r),
    .color_cb            (color_cb_r),
    .color_cr            (color_cr_r),
    .out_free            (out_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_index     (out_pixel_index),
    .out_left_value      (out_left_value),
    .out_right_value     (out_right_value),
    .out_repeat_next_row (out_repeat_next_row),
    .out_last            (out_last)
  );

endmodule

FILE: hdl/tog_checker.sv
module tog_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] out_pixel_index,
  input logic [15:0] out_left_value,
  input logic [15:0] out_right_value,
  input logic        out_repeat_next_row,
  input logic        out_last
);

  // A stalled pair holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index) &&
      $stable(out_left_value) && $stable(out_right_value))
    else $error("output pair changed while stalled");

  // No new item while a glyph is still being sent
  a_busy_mid_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a glyph");

  // Pairs of one glyph follow back to back with the same repeat flag
  a_glyph_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && $stable(out_repeat_next_row))
    else $error("gap or repeat flag change inside a glyph");

  // A cursor command does not stall the input
  a_cursor_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> in_ready)
    else $error("cursor command stalled the input");

endmodule

bind text_overlay_glyph_renderer_core tog_checker u_chk (.*);
